@@ design/rdf_pkg.sv @@
// Shared types, constants and twiddle lookup for the radix-2 split DFT block.
`timescale 1ns / 1ps
package rdf_pkg;

  localparam int TW_POINTS = 64;
  localparam int TW_IDX_W = 6;
  localparam int TW_W = 16;
  localparam int BIN_W = 6;
  localparam int OUT_W = 23;
  localparam int LG_W = 3;
  localparam int OUT_TDATA_W = 56;
  localparam logic [LG_W-1:0] LG_RESET = 3'd6;

  localparam logic signed [TW_W-1:0] QUARTER_COS [17] = '{
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
    16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
    16'sd12540, 16'sd9512, 16'sd6393, 16'sd3212, 16'sd0
  };

  typedef struct packed {
    logic            bsel;
    logic [LG_W-1:0] lg;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ACC, B_DRAIN1, B_DRAIN2, B_ROUND, B_MULA, B_MULB, B_EMIT
  } back_state_t;

  // Q1.15 cos(2*pi*k/64), rounded, +1 clipped to 32767
  function automatic logic signed [TW_W-1:0] tw_cos(input logic [TW_IDX_W-1:0] k);
    logic [3:0] q;
    logic [4:0] qr;
    logic signed [TW_W-1:0] v;
    q  = k[3:0];
    qr = 5'd16 - {1'b0, q};
    unique case (k[5:4])
      2'd0: v = QUARTER_COS[q];
      2'd1: v = -QUARTER_COS[qr];
      2'd2: v = (q == 4'd0) ? 16'sh8000 : -QUARTER_COS[q];
      default: v = QUARTER_COS[qr];
    endcase
    return v;
  endfunction

endpackage

@@ design/rdf_front.sv @@
// Front end: register write, sample intake, frame counting and job hand-off.
`timescale 1ns / 1ps
module rdf_front import rdf_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int DIN_W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [LG_W-1:0]                   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [DIN_W-1:0]                  s_tdata,
  input  logic                              fifo_full,
  output logic                              push,
  output job_t                              push_job,
  output logic                              wr_en,
  output logic [$clog2(MAX_POINTS):0]       wr_addr,
  output logic [SAMPLE_BITS-1:0]            wr_data
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [LG_W-1:0] points_log2;
  logic [AW-1:0]   load_count;
  logic            wbuf;
  logic [LG_W-1:0] lg_eff;
  logic [AW:0]     n_full;
  logic [AW-1:0]   last_idx;
  logic            accept;

  always_comb begin
    if (points_log2 == '0) begin
      lg_eff = LG_W'(1);
    end else if (points_log2 > LG_W'(AW)) begin
      lg_eff = LG_W'(AW);
    end else begin
      lg_eff = points_log2;
    end
  end

  assign n_full   = (AW+1)'(1) << lg_eff;
  assign last_idx = AW'(n_full - (AW+1)'(1));
  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (load_count == last_idx);
  assign push_job = '{bsel: wbuf, lg: lg_eff};
  assign wr_en    = accept;
  assign wr_addr  = {wbuf, load_count};
  assign wr_data  = s_tdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      points_log2 <= LG_RESET;
      load_count  <= '0;
      wbuf        <= 1'b0;
    end else if (cfg_we) begin
      // drop any partly loaded frame
      points_log2 <= cfg_wdata;
      load_count  <= '0;
    end else if (accept) begin
      if (load_count == last_idx) begin
        load_count <= '0;
        wbuf       <= ~wbuf;
      end else begin
        load_count <= load_count + AW'(1);
      end
    end
  end

endmodule

@@ design/rdf_fifo.sv @@
// Two-entry job queue between the front end and the transform engine.
`timescale 1ns / 1ps
module rdf_fifo import rdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/rdf_back.sv @@
// Transform engine: double-buffered sample store, per-bin MAC loop, combine, output register.
`timescale 1ns / 1ps
module rdf_back import rdf_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_POINTS):0]  wr_addr,
  input  logic [SAMPLE_BITS-1:0]       wr_data,
  input  logic                         job_valid,
  input  job_t                         job,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_TDATA_W-1:0]       m_tdata,
  output logic                         m_tlast
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int SB = SAMPLE_BITS;
  localparam int PRD_W = SB + TW_W;
  localparam int ACC_W = PRD_W + AW;
  localparam int EW = ACC_W - 14;
  localparam int PW = EW + TW_W;
  localparam int RW = PW - 14;
  localparam int SW = (RW + 1 > OUT_W + 1) ? RW + 1 : OUT_W + 1;
  localparam int PAY_W = BIN_W + 2 * OUT_W;

  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [SB-1:0] store [2*MAX_POINTS];
  logic signed [SB-1:0] rd_data;

  back_state_t state, state_next;
  logic [AW-1:0] j;
  logic [AW-1:0] bin;
  logic [AW:0]   n_full;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] half_mask;

  // MAC pipeline
  logic                 s1_valid, s1_par;
  logic [TW_IDX_W-1:0]  s1_k;
  logic                 s2_valid, s2_par;
  logic signed [PRD_W-1:0] prod_c, prod_s;
  logic signed [ACC_W-1:0] acc_er, acc_ei, acc_or, acc_oi;

  logic signed [EW-1:0] er, ei, orr, oi;
  logic signed [PW-1:0] m0, m1, m2, m3;
  logic signed [PW-1:0] mult1, mult2;

  logic [AW-1:0]          i_idx, m_idx;
  logic [2*AW-1:0]        im;
  logic [2*AW+6:0]        kx;
  logic [TW_IDX_W-1:0]    k_next;
  logic [AW+5:0]          wx;
  logic [TW_IDX_W-1:0]    widx;
  logic signed [TW_W-1:0] wr, wi, tc, ts;

  logic signed [PW:0]   pr_t, pi_t;
  logic signed [SW-1:0] re_sum, im_sum;
  logic signed [OUT_W-1:0] re_sat, im_sat;

  logic out_valid, out_last, load, acc_clear, in_acc;
  logic [PAY_W-1:0] out_data;

  assign n_full    = (AW+1)'(1) << job.lg;
  assign last_idx  = AW'(n_full - (AW+1)'(1));
  assign half_mask = last_idx >> 1;

  // sample store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[{job.bsel, j}];
  end

  // even/odd twiddle index: 2*i*m*step = i*m << (7 - lg)
  assign i_idx  = bin & half_mask;
  assign m_idx  = j >> 1;
  assign im     = (2*AW)'(i_idx) * (2*AW)'(m_idx);
  assign kx     = (2*AW+7)'(im) << (3'd7 - job.lg);
  assign k_next = kx[TW_IDX_W-1:0];
  assign tc     = tw_cos(s1_k);
  assign ts     = tw_cos(s1_k + TW_IDX_W'(16));

  // combine twiddle W(bin * step)
  assign wx   = (AW+6)'(bin) << (3'd6 - job.lg);
  assign widx = wx[TW_IDX_W-1:0];
  assign wr   = tw_cos(widx);
  assign wi   = tw_cos(widx + TW_IDX_W'(16));

  assign mult1 = PW'(wr) * ((state == B_MULA) ? PW'(orr) : PW'(oi));
  assign mult2 = PW'(wi) * ((state == B_MULA) ? PW'(oi) : PW'(orr));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_par <= j[0];
    s1_k   <= k_next;
    s2_par <= s1_par;
    prod_c <= PRD_W'(rd_data) * PRD_W'(tc);
    prod_s <= PRD_W'(rd_data) * PRD_W'(ts);
    if (acc_clear) begin
      acc_er <= '0;
      acc_ei <= '0;
      acc_or <= '0;
      acc_oi <= '0;
    end else if (s2_valid) begin
      if (s2_par) begin
        acc_or <= acc_or + ACC_W'(prod_c);
        acc_oi <= acc_oi + ACC_W'(prod_s);
      end else begin
        acc_er <= acc_er + ACC_W'(prod_c);
        acc_ei <= acc_ei + ACC_W'(prod_s);
      end
    end
  end

  // round half-DFT sums, then the complex products
  always_ff @(posedge clk) begin
    if (state == B_ROUND) begin
      er  <= EW'(((ACC_W+1)'(acc_er) + (ACC_W+1)'(16384)) >>> 15);
      ei  <= EW'(((ACC_W+1)'(acc_ei) + (ACC_W+1)'(16384)) >>> 15);
      orr <= EW'(((ACC_W+1)'(acc_or) + (ACC_W+1)'(16384)) >>> 15);
      oi  <= EW'(((ACC_W+1)'(acc_oi) + (ACC_W+1)'(16384)) >>> 15);
    end
    if (state == B_MULA) begin
      m0 <= mult1;
      m1 <= mult2;
    end
    if (state == B_MULB) begin
      m2 <= mult1;
      m3 <= mult2;
    end
  end

  assign pr_t   = ((PW+1)'(m0) - (PW+1)'(m1) + (PW+1)'(16384)) >>> 15;
  assign pi_t   = ((PW+1)'(m2) + (PW+1)'(m3) + (PW+1)'(16384)) >>> 15;
  assign re_sum = SW'(er) + SW'($signed(pr_t[RW-1:0]));
  assign im_sum = SW'(ei) + SW'($signed(pi_t[RW-1:0]));

  always_comb begin
    if (re_sum > SAT_MAX) begin
      re_sat = SAT_MAX[OUT_W-1:0];
    end else if (re_sum < SAT_MIN) begin
      re_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      re_sat = re_sum[OUT_W-1:0];
    end
    if (im_sum > SAT_MAX) begin
      im_sat = SAT_MAX[OUT_W-1:0];
    end else if (im_sum < SAT_MIN) begin
      im_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      im_sat = im_sum[OUT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (job_valid) state_next = B_ACC;
      B_ACC:    if (j == last_idx) state_next = B_DRAIN1;
      B_DRAIN1: state_next = B_DRAIN2;
      B_DRAIN2: state_next = B_ROUND;
      B_ROUND:  state_next = B_MULA;
      B_MULA:   state_next = B_MULB;
      B_MULB:   state_next = B_EMIT;
      B_EMIT: begin
        if (!out_valid || m_tready) begin
          state_next = (bin == last_idx) ? B_IDLE : B_ACC;
        end
      end
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_acc    = (state == B_ACC);
    acc_clear = (state == B_IDLE) || (state == B_ROUND);
    load      = (state == B_EMIT) && (!out_valid || m_tready);
    pop       = load && (bin == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      j         <= '0;
      bin       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE) begin
        j   <= '0;
        bin <= '0;
      end else if (state == B_ACC) begin
        j <= j + AW'(1);
      end else if (load) begin
        j   <= '0;
        bin <= bin + AW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {im_sat, re_sat, BIN_W'(bin)};
      out_last <= (bin == last_idx);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_data);
  assign m_tlast  = out_last;

endmodule

@@ design/radix2_split_dft.sv @@
// Top level of the radix-2 split DFT block.
// Usage:
//   cfg_we/cfg_wdata write points_log2 (frame length N = 2^points_log2, clamped
//   to 1..log2(MAX_POINTS)); a write restarts frame loading. Write only when idle.
//   Samples enter on the s_ channel, one per item. After the N-th sample of a
//   frame the engine emits N bins, 0..N-1, on the m_ channel; m_tlast marks bin N-1.
//   Each bin runs the single real-by-complex MAC loop over the sample store
//   (state B_ACC), then the pipeline drain states B_DRAIN1 and B_DRAIN2, the
//   rounding state B_ROUND, the complex combine multiply states B_MULA and
//   B_MULB, and B_EMIT, which loads the output register.
//   The store is double buffered: the next frame loads while the previous one
//   is transformed; s_tready drops only while two full frames are queued.
//   A stall on m_tready holds the output register and freezes the engine;
//   the front keeps loading until both buffers are full.
//   Reset (rst, synchronous) sets points_log2 to 6, empties the job queue and
//   drops any partial frame. Store contents need no reset.
`timescale 1ns / 1ps
module radix2_split_dft import rdf_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [LG_W-1:0]                   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_TDATA_W-1:0]            m_tdata,   // bin_index, real_part, imag_part
  output logic                              m_tlast    // last_bin
);

  localparam int DIN_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW = $clog2(MAX_POINTS);

  logic                   push, pop, fifo_full, job_valid;
  job_t                   push_job, head_job;
  logic                   wr_en;
  logic [AW:0]            wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;

  rdf_front #(
    .MAX_POINTS(MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .DIN_W(DIN_W)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .fifo_full(fifo_full), .push(push), .push_job(push_job),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  rdf_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_job(push_job), .pop(pop),
    .full(fifo_full), .not_empty(job_valid), .head(head_job)
  );

  rdf_back #(
    .MAX_POINTS(MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .job_valid(job_valid), .job(head_job), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
